FILE: rtl/stma_pkg.sv
package stma_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int COORD_BITS  = 10;
  localparam int ADDR_BITS   = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_BITS    = 2 * COORD_BITS;
  localparam int VAL_BITS    = 32;
  localparam int SUM_BITS    = VAL_BITS + 1;
  localparam int ENTRY_BITS  = KEY_BITS + VAL_BITS;

  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // Write and read requests from the sequencer to the two entry memories.
  typedef struct packed {
    logic                  a_we;
    logic                  b_we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [ENTRY_BITS-1:0] wdata;
    logic [ADDR_BITS-1:0]  raddr;
  } mem_req_t;

endpackage

FILE: rtl/stma_ram.sv
module stma_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/stma_seq.sv
module stma_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     req_type,
  input  logic [stma_pkg::COORD_BITS-1:0] row_index,
  input  logic [stma_pkg::COORD_BITS-1:0] col_index,
  input  logic [stma_pkg::VAL_BITS-1:0]   entry_value,
  output stma_pkg::mem_req_t             mem_req,
  input  logic [stma_pkg::ENTRY_BITS-1:0] a_rdata,
  input  logic [stma_pkg::ENTRY_BITS-1:0] b_rdata,
  output logic                           result_valid,
  output logic [9:0]                     out_row,
  output logic [9:0]                     out_col,
  output logic [stma_pkg::SUM_BITS-1:0]   out_value,
  output logic                           out_last
);
  import stma_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KEY  = 3'd1;
  localparam logic [2:0] ST_FA   = 3'd2;
  localparam logic [2:0] ST_FB   = 3'd3;
  localparam logic [2:0] ST_FA2  = 3'd4;

  logic [2:0]           state;
  logic [CNT_BITS-1:0]  a_cnt, b_cnt;
  logic [CNT_BITS-1:0]  scan_idx;
  logic                 rd_vld;
  logic [ADDR_BITS-1:0] rd_idx;
  logic                 have_prev, best_found;
  logic [KEY_BITS-1:0]  prev_key, best_key;
  logic                 has_a, any_b;
  logic [VAL_BITS-1:0]  a1_val;
  logic [ADDR_BITS-1:0] a1_idx;
  logic                 pend_vld;
  logic [KEY_BITS-1:0]  pend_key;
  logic [SUM_BITS-1:0]  pend_val;

  logic [CNT_BITS-1:0]  limit;
  logic                 issue, scan_end;
  logic [KEY_BITS-1:0]  ka, kb, sel_k;
  logic [VAL_BITS-1:0]  va, vb;
  logic                 a_ok, b_ok, ca, cb, upd;
  logic                 prod_vld;
  logic [SUM_BITS-1:0]  prod_val;

  assign busy = (state != ST_IDLE);
  assign ka   = a_rdata[ENTRY_BITS-1:VAL_BITS];
  assign kb   = b_rdata[ENTRY_BITS-1:VAL_BITS];
  assign va   = a_rdata[VAL_BITS-1:0];
  assign vb   = b_rdata[VAL_BITS-1:0];
  assign a_ok = rd_vld && ({1'b0, rd_idx} < a_cnt);
  assign b_ok = rd_vld && ({1'b0, rd_idx} < b_cnt);

  always_comb begin
    unique case (state)
      ST_KEY:  limit = (a_cnt > b_cnt) ? a_cnt : b_cnt;
      ST_FB:   limit = b_cnt;
      ST_FA,
      ST_FA2:  limit = a_cnt;
      default: limit = '0;
    endcase
  end

  assign issue    = busy && (scan_idx < limit);
  assign scan_end = busy && (scan_idx >= limit) && !rd_vld;

  // Smallest key above the previous one among the two entries read this cycle.
  always_comb begin
    ca = a_ok && (!have_prev || ka > prev_key);
    cb = b_ok && (!have_prev || kb > prev_key);
    if (ca && cb) begin
      sel_k = (ka < kb) ? ka : kb;
    end else if (ca) begin
      sel_k = ka;
    end else begin
      sel_k = kb;
    end
    upd = (state == ST_KEY) && (ca || cb) && (!best_found || sel_k < best_key);
  end

  // One result can come from a matching read or from the end of the B pass.
  always_comb begin
    prod_vld = 1'b0;
    prod_val = {vb[VAL_BITS-1], vb};
    case (state)
      ST_FB: begin
        if (b_ok && kb == prev_key) begin
          prod_vld = 1'b1;
          prod_val = has_a ? ({a1_val[VAL_BITS-1], a1_val} + {vb[VAL_BITS-1], vb})
                           : {vb[VAL_BITS-1], vb};
        end else if (scan_end && has_a && !any_b) begin
          prod_vld = 1'b1;
          prod_val = {a1_val[VAL_BITS-1], a1_val};
        end
      end
      ST_FA2: begin
        if (a_ok && ka == prev_key) begin
          prod_vld = 1'b1;
          prod_val = {va[VAL_BITS-1], va};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_req.a_we  = !busy && start && req_type == REQ_LOAD_A
                    && a_cnt < CNT_BITS'(MAX_ENTRIES);
    mem_req.b_we  = !busy && start && req_type == REQ_LOAD_B
                    && b_cnt < CNT_BITS'(MAX_ENTRIES);
    mem_req.waddr = (req_type == REQ_LOAD_A) ? a_cnt[ADDR_BITS-1:0]
                                             : b_cnt[ADDR_BITS-1:0];
    mem_req.wdata = {row_index, col_index, entry_value};
    mem_req.raddr = scan_idx[ADDR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    out_last     <= 1'b0;
    rd_vld       <= issue;
    rd_idx       <= scan_idx[ADDR_BITS-1:0];
    if (issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (upd) begin
      best_found <= 1'b1;
      best_key   <= sel_k;
    end
    // The previous result goes out once the next one exists, so the final
    // one can carry its last flag.
    if (prod_vld) begin
      if (pend_vld) begin
        result_valid <= 1'b1;
        out_row      <= pend_key[KEY_BITS-1:COORD_BITS];
        out_col      <= pend_key[COORD_BITS-1:0];
        out_value    <= pend_val;
      end
      pend_vld <= 1'b1;
      pend_key <= prev_key;
      pend_val <= prod_val;
    end

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (mem_req.a_we) a_cnt <= a_cnt + 1'b1;
          if (mem_req.b_we) b_cnt <= b_cnt + 1'b1;
          if (req_type == REQ_COMPUTE) begin
            state      <= ST_KEY;
            scan_idx   <= '0;
            have_prev  <= 1'b0;
            best_found <= 1'b0;
            pend_vld   <= 1'b0;
          end
        end
      end
      ST_KEY: begin
        if (scan_end) begin
          scan_idx <= '0;
          if (best_found) begin
            state     <= ST_FA;
            have_prev <= 1'b1;
            prev_key  <= best_key;
            has_a     <= 1'b0;
          end else begin
            if (pend_vld) begin
              result_valid <= 1'b1;
              out_last     <= 1'b1;
              out_row      <= pend_key[KEY_BITS-1:COORD_BITS];
              out_col      <= pend_key[COORD_BITS-1:0];
              out_value    <= pend_val;
            end
            pend_vld <= 1'b0;
            a_cnt    <= '0;
            b_cnt    <= '0;
            state    <= ST_IDLE;
          end
        end
      end
      ST_FA: begin
        if (a_ok && !has_a && ka == prev_key) begin
          has_a  <= 1'b1;
          a1_val <= va;
          a1_idx <= rd_idx;
        end
        if (scan_end) begin
          state    <= ST_FB;
          scan_idx <= '0;
          any_b    <= 1'b0;
        end
      end
      ST_FB: begin
        if (b_ok && kb == prev_key) begin
          any_b <= 1'b1;
        end
        if (scan_end) begin
          if (has_a) begin
            state    <= ST_FA2;
            scan_idx <= {1'b0, a1_idx} + 1'b1;
          end else begin
            state      <= ST_KEY;
            scan_idx   <= '0;
            best_found <= 1'b0;
          end
        end
      end
      ST_FA2: begin
        if (scan_end) begin
          state      <= ST_KEY;
          scan_idx   <= '0;
          best_found <= 1'b0;
        end
      end
      default: state <= ST_IDLE;
    endcase

    if (rst) begin
      state        <= ST_IDLE;
      a_cnt        <= '0;
      b_cnt        <= '0;
      scan_idx     <= '0;
      rd_vld       <= 1'b0;
      pend_vld     <= 1'b0;
      result_valid <= 1'b0;
      out_last     <= 1'b0;
      have_prev    <= 1'b0;
      best_found   <= 1'b0;
    end
  end

endmodule

FILE: rtl/sparse_triplet_matrix_add_top.sv
// Channel   Direction  Transfer condition      Payload
// request   in         start && !busy          req_type, row_index, col_index, entry_value
// result    out        result_valid (1 cycle)  out_row, out_col, out_value, out_last
//
// A load leaves busy low, so loads can be issued back to back.
// A compute holds busy for one key scan plus, for each of the D distinct coordinates, a key
// scan, an A scan, a B scan and, when A holds the coordinate, a scan of the rest of A.
// A scan reads the entries in order through the single read port of each entry memory.
// Reset is synchronous and empties both lists; no clearing pass is needed.
// The receiver cannot stall: every result is shown for exactly one cycle.
module sparse_triplet_matrix_add_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     req_type,
  input  logic [9:0]                     row_index,
  input  logic [9:0]                     col_index,
  input  logic signed [31:0]             entry_value,
  output logic                           result_valid,
  output logic [9:0]                     out_row,
  output logic [9:0]                     out_col,
  output logic signed [32:0]             out_value,
  output logic                           out_last
);
  import stma_pkg::*;

  mem_req_t              mem_req;
  logic [ENTRY_BITS-1:0] a_rdata;
  logic [ENTRY_BITS-1:0] b_rdata;

  // Matrix A entries, stored as {row, column, value} in load order.
  stma_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_ENTRIES)) u_a_ram (
    .clk   (clk),
    .we    (mem_req.a_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (a_rdata)
  );

  // Matrix B entries, same layout; scans read both memories at one address.
  stma_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_ENTRIES)) u_b_ram (
    .clk   (clk),
    .we    (mem_req.b_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (b_rdata)
  );

  // The sequencer finds each next coordinate in ascending order, then walks
  // the lists to build the sums for it, holding one result back so that the
  // final one can be flagged.
  stma_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .row_index    (row_index),
    .col_index    (col_index),
    .entry_value  (entry_value),
    .mem_req      (mem_req),
    .a_rdata      (a_rdata),
    .b_rdata      (b_rdata),
    .result_valid (result_valid),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .out_last     (out_last)
  );

endmodule

FILE: rtl/stma_checker.sv
module stma_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] req_type,
  input logic       result_valid,
  input logic       out_last
);
  import stma_pkg::*;

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    out_last |-> result_valid) else $error("last flag without a result");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == REQ_COMPUTE |=> busy)
    else $error("compute transfer did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_last |-> !busy) else $error("busy after final result");

  a_result_in_compute: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result outside a compute");

endmodule

bind sparse_triplet_matrix_add_top stma_checker u_stma_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .req_type     (req_type),
  .result_valid (result_valid),
  .out_last     (out_last)
);
